FILE: hw/rtl/mwpo_pkg.sv
package mwpo_pkg;

  // default build parameters
  localparam int unsigned PHASE_BITS_DEFAULT      = 32;
  localparam int unsigned SINE_TABLE_BITS_DEFAULT = 10;
  localparam int unsigned OUT_FRAC_BITS_DEFAULT   = 16;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WIDTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_RECIP = 3'd3;

  // register reset values
  localparam logic [31:0] PHASE_INC_RESET   = 32'd0;
  localparam logic [2:0]  WAVE_SELECT_RESET = 3'd0;
  localparam logic [15:0] PULSE_WIDTH_RESET = 16'd32768;
  localparam logic [31:0] PULSE_RECIP_RESET = 32'd131072;

  // waveform codes
  localparam logic [2:0] WAVE_PHASE    = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SINE     = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_SAW      = 3'd4;
  localparam logic [2:0] WAVE_SPARSE   = 3'd5;
  localparam logic [2:0] WAVE_GATE     = 3'd6;

  // pi/2 in q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [31:0] phase_increment;
    logic [2:0]  wave_select;
    logic [15:0] pulse_width;
    logic [31:0] pulse_reciprocal;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOOK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic step;
    logic mul;
    logic look;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // taylor term divisor (n+1)(n+2) for odd n
  function automatic logic [63:0] taylor_div(input logic [63:0] val, input int unsigned n);
    logic [63:0] res;
    case (n)
      1:       res = val / 6;
      3:       res = val / 20;
      5:       res = val / 42;
      7:       res = val / 72;
      9:       res = val / 110;
      11:      res = val / 156;
      13:      res = val / 210;
      15:      res = val / 272;
      17:      res = val / 342;
      19:      res = val / 420;
      default: res = val;
    endcase
    return res;
  endfunction

  // one quarter-wave sine entry, rounded half up and clamped to one
  function automatic logic [63:0] sine_entry(input int unsigned k, input int unsigned tbits,
                                             input int unsigned fbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic        neg;
    x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = 64'd0;
    neg  = 1'b0;
    for (int unsigned n = 1; n < 20; n += 2) begin
      if (term != 64'd0) begin
        if (neg) sum = sum - term;
        else     sum = sum + term;
        neg  = !neg;
        term = taylor_div((term * x2) >> 30, n);
      end
    end
    v = (sum + (64'd1 << (29 - fbits))) >> (30 - fbits);
    if (v > (64'd1 << fbits)) v = 64'd1 << fbits;
    return v;
  endfunction

endpackage

FILE: hw/rtl/mwpo_cfg.sv
module mwpo_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mwpo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0]      cfg_data,
  output mwpo_pkg::cfg_regs_t                  cfg
);
  import mwpo_pkg::*;

  // writes are always accepted
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_increment  <= PHASE_INC_RESET;
      cfg.wave_select      <= WAVE_SELECT_RESET;
      cfg.pulse_width      <= PULSE_WIDTH_RESET;
      cfg.pulse_reciprocal <= PULSE_RECIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_INC:   cfg.phase_increment  <= cfg_data[31:0];
        REG_WAVE_SELECT: cfg.wave_select      <= cfg_data[2:0];
        REG_PULSE_WIDTH: cfg.pulse_width      <= cfg_data[15:0];
        REG_PULSE_RECIP: cfg.pulse_reciprocal <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/mwpo_ctrl.sv
module mwpo_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 tick,
  output logic                 in_ready,
  input  mwpo_pkg::dp_status_t status,
  output mwpo_pkg::dp_cmd_t    cmd
);
  import mwpo_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sequencer: accumulate, multiply, table read, emit
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && tick) begin
          cmd.step   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/mwpo_datapath.sv
module mwpo_datapath #(
  parameter int unsigned PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEFAULT,
  parameter int unsigned SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEFAULT,
  parameter int unsigned OUT_FRAC_BITS   = mwpo_pkg::OUT_FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mwpo_pkg::cfg_regs_t           cfg,
  input  mwpo_pkg::dp_cmd_t             cmd,
  output mwpo_pkg::dp_status_t          status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [OUT_FRAC_BITS+1:0] sample_value
);
  import mwpo_pkg::*;

  localparam int unsigned F        = OUT_FRAC_BITS;
  localparam int unsigned T        = SINE_TABLE_BITS;
  localparam int unsigned OW       = F + 2;
  localparam int unsigned AW       = T + 1;
  localparam int unsigned TAB_LEN  = (1 << T) + 1;
  localparam int unsigned TAB_HALF = 1 << T;

  localparam logic signed [OW-1:0] ONE_VAL  = OW'(1 << F);
  localparam logic signed [OW-1:0] HALF_VAL = OW'(1 << (F - 1));
  localparam logic [31:0]          HALF_P   = 32'h8000_0000;
  localparam logic [47:0]          R_ONE    = 48'h1_0000_0000;

  typedef logic [F:0] rom_word_t;
  typedef rom_word_t rom_t [TAB_LEN];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k < TAB_LEN; k++) begin
      r[k] = rom_word_t'(sine_entry(k, T, F));
    end
    return r;
  endfunction

  // quarter-wave sine table
  localparam rom_t SINE_ROM = build_rom();

  logic [PHASE_BITS-1:0] acc;
  logic [PHASE_BITS-1:0] inc;
  logic [31:0]           p32;
  logic [47:0]           prod;
  logic                  over;
  logic [32:0]           r_sat;
  logic [31:0]           sine_src;
  logic [T-1:0]          tab_idx;
  logic [AW-1:0]         rom_addr;
  rom_word_t             rom_q;
  logic                  neg;
  logic [31:0]           tri_dist;
  logic [31:0]           tri_mag;
  logic [2*F+1:0]        sq;
  logic signed [OW-1:0]  shaped;

  // align increment and phase to q0.32
  if (PHASE_BITS >= 32) begin : g_wide
    assign inc = PHASE_BITS'(cfg.phase_increment) << (PHASE_BITS - 32);
    assign p32 = acc[PHASE_BITS-1 -: 32];
  end else begin : g_narrow
    assign inc = PHASE_BITS'(cfg.phase_increment >> (32 - PHASE_BITS));
    assign p32 = 32'(acc) << (32 - PHASE_BITS);
  end

  // phase accumulator, wraps modulo one
  always_ff @(posedge clk) begin
    if (rst)           acc <= '0;
    else if (cmd.step) acc <= acc + inc;
  end

  // ratio product for sparse lfo and pulse compare
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 48'(p32[31:16]) * 48'(cfg.pulse_reciprocal);
      over <= p32 > {cfg.pulse_width, 16'h0000};
    end
  end

  // ratio saturates at one, halved for the sine argument
  assign r_sat    = (prod > R_ONE) ? R_ONE[32:0] : prod[32:0];
  assign sine_src = (cfg.wave_select == WAVE_SPARSE) ? r_sat[32:1] : p32;
  assign tab_idx  = sine_src[29 -: T];
  assign rom_addr = sine_src[30] ? AW'(TAB_HALF) - {1'b0, tab_idx} : {1'b0, tab_idx};

  // table read
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      rom_q <= SINE_ROM[rom_addr];
      neg   <= sine_src[31];
    end
  end

  // triangle distance from half
  assign tri_dist = (p32 >= HALF_P) ? p32 - HALF_P : HALF_P - p32;
  assign tri_mag  = HALF_P - tri_dist;
  assign sq       = (2*F+2)'(rom_q) * (2*F+2)'(rom_q);

  // waveform shaping
  always_comb begin
    case (cfg.wave_select)
      WAVE_PHASE:    shaped = $signed({2'b00, p32[31 -: F]});
      WAVE_TRIANGLE: shaped = -$signed({2'b00, tri_mag[31 -: F]});
      WAVE_SINE:     shaped = neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
      WAVE_SQUARE:   shaped = over ? -HALF_VAL : HALF_VAL;
      WAVE_SAW:      shaped = $signed({2'b00, p32[31 -: F]}) - HALF_VAL;
      WAVE_SPARSE:   shaped = over ? '0 : $signed({1'b0, sq[2*F -: F+1]});
      WAVE_GATE:     shaped = over ? '0 : ONE_VAL;
      default:       shaped = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) sample_value <= shaped;
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: hw/rtl/multi_waveform_phase_oscillator.sv
// channel | direction | signals                           | transfer when
// in      | in        | in_valid, in_ready, tick          | in_valid && in_ready
// out     | out       | out_valid, out_ready, sample_value| out_valid && out_ready
// cfg     | in        | cfg_valid, cfg_ready, cfg_index,  | cfg_valid && cfg_ready
//         |           | cfg_data                          |
//
// a tick of one steps through accumulate, ratio multiply, registered
// sine table read, shape into the output register; the sequencer takes the
// next item once the output stage is loaded. a tick of zero is taken without a step.
// the output register holds one finished sample while the next is computed;
// the last step waits only while that register is full and not taken.
// reset clears the phase, the configuration registers and the output valid flag; no clearing pass.
module multi_waveform_phase_oscillator #(
  parameter int unsigned PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEFAULT,
  parameter int unsigned SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEFAULT,
  parameter int unsigned OUT_FRAC_BITS   = mwpo_pkg::OUT_FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               tick,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [OUT_FRAC_BITS+1:0]    sample_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mwpo_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mwpo_pkg::*;

  cfg_regs_t  cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration registers
  mwpo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  mwpo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .tick     (tick),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // phase accumulator and wave shaping
  mwpo_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .OUT_FRAC_BITS   (OUT_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .sample_value (sample_value)
  );

endmodule

FILE: tb/multi_waveform_phase_oscillator_tb.sv
module multi_waveform_phase_oscillator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwpo_pkg::*;

  localparam int unsigned FRAC     = OUT_FRAC_BITS_DEFAULT;
  localparam int unsigned TBITS    = SINE_TABLE_BITS_DEFAULT;
  localparam int unsigned SAMPLE_W = FRAC + 2;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint unsigned HALF_TURN = 64'd1 << 31;
  localparam longint unsigned FULL_TURN = 64'd1 << 32;

  // index with no register behind it, select code with no waveform
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 3'd5;
  localparam logic [2:0]             WAVE_UNUSED = 3'd7;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_CYCLES  = 300;
  localparam int IDLE_PCT      = 22;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic tick = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PHASE_INC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // oscillator copy kept in step with accepted transfers
  logic [31:0] osc_inc;
  logic [2:0]  osc_sel;
  logic [15:0] osc_pw;
  logic [31:0] osc_recip;
  logic [31:0] osc_phase;
  longint unsigned sine_rom [0:(1 << TBITS)];

  logic [SAMPLE_W-1:0] expected_samples [$];
  int errors = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  bit stall_go = 1'b0;
  bit stall_seen = 1'b0;
  int stall_left = 0;

  multi_waveform_phase_oscillator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tick         (tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // quarter-wave table from a q30 taylor series, rounded and clamped
  function automatic void build_sine_rom();
    longint unsigned x, x2, term, acc, v;
    int unsigned n;
    bit sub;
    for (int k = 0; k <= (1 << TBITS); k++) begin
      x = (HALF_PI_Q30 * 64'(k)) >> TBITS;
      x2 = (x * x) >> 30;
      term = x;
      acc = 0;
      sub = 1'b0;
      n = 1;
      while (n < 20 && term != 0) begin
        acc = sub ? acc - term : acc + term;
        sub = !sub;
        term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
        n += 2;
      end
      v = (acc + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      sine_rom[k] = (v > 64'(ONE)) ? 64'(ONE) : v;
    end
  endfunction

  // quadrant from the top two phase bits, index from the next ones
  function automatic longint sine_lookup(input logic [31:0] p);
    logic [1:0] quad;
    int unsigned idx;
    longint mag;
    quad = p[31:30];
    idx = p[29 -: TBITS];
    if (quad[0]) idx = (1 << TBITS) - idx;
    mag = longint'(sine_rom[idx]);
    return quad[1] ? -mag : mag;
  endfunction

  // waveform value for a new phase under the current settings
  function automatic logic [SAMPLE_W-1:0] shape_sample(input logic [31:0] p);
    longint unsigned p64, thr, gap, ratio, mag;
    longint val;
    p64 = {32'd0, p};
    thr = 64'(osc_pw) << 16;
    case (osc_sel)
      WAVE_PHASE: val = longint'(p64 >> (32 - FRAC));
      WAVE_TRIANGLE: begin
        gap = (p64 >= HALF_TURN) ? p64 - HALF_TURN : HALF_TURN - p64;
        val = -longint'((HALF_TURN - gap) >> (32 - FRAC));
      end
      WAVE_SINE: val = sine_lookup(p);
      WAVE_SQUARE: val = (p64 > thr) ? -(ONE / 2) : ONE / 2;
      WAVE_SAW: val = longint'(p64 >> (32 - FRAC)) - ONE / 2;
      WAVE_SPARSE: begin
        if (p64 > thr) begin
          val = 0;
        end else begin
          // ratio p/pw saturates at one turn, then sine of half of it, squared
          ratio = (p64 >> 16) * 64'(osc_recip);
          if (ratio > FULL_TURN) ratio = FULL_TURN;
          val = sine_lookup(ratio[32:1]);
          mag = (val < 0) ? -val : val;
          val = longint'((mag * mag) >> FRAC);
        end
      end
      WAVE_GATE: val = (p64 > thr) ? 0 : ONE;
      default: val = 0;
    endcase
    return val[SAMPLE_W-1:0];
  endfunction

  // offer one tick after an optional random gap, predict on transfer
  task automatic send_tick(input logic t);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (!in_ready);
    if (t) begin
      osc_phase = osc_phase + osc_inc;
      expected_samples.push_back(shape_sample(osc_phase));
    end
  endtask

  // one register transfer; valid is left high for a following write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PHASE_INC:   osc_inc = data;
      REG_WAVE_SELECT: osc_sel = data[2:0];
      REG_PULSE_WIDTH: osc_pw = data[15:0];
      REG_PULSE_RECIP: osc_recip = data;
      default: ;
    endcase
  endtask

  // stop offering, wait for every sample, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all registers rewritten while idle; unused upper bits get noise
  task automatic set_config(input logic [2:0] sel, input logic [31:0] inc,
                            input logic [15:0] pw, input logic [31:0] recip);
    wait_drained();
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_PHASE_INC, inc);
    write_reg(REG_WAVE_SELECT, {29'($urandom), sel});
    write_reg(REG_PULSE_WIDTH, {16'($urandom), pw});
    write_reg(REG_PULSE_RECIP, recip);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // software-style reciprocal of a pulse width, capped to 32 bits
  function automatic logic [31:0] recip_of(input logic [15:0] pw);
    longint unsigned wide;
    wide = FULL_TURN / 64'(pw);
    return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  // reset values: zero increment holds the phase at zero
  task automatic test_reset_values();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // every select code once, the unused one included
  task automatic test_wave_shapes();
    for (int w = WAVE_PHASE; w <= WAVE_UNUSED; w++) begin
      set_config(3'(w), 32'h3579_BDF1, PULSE_WIDTH_RESET, PULSE_RECIP_RESET);
      send_tick(1'b1);
    end
  endtask

  // exact wrap to zero, largest legal step, step above one half
  task automatic test_phase_wrap();
    set_config(WAVE_PHASE, 32'h4000_0000, PULSE_WIDTH_RESET, PULSE_RECIP_RESET);
    repeat (4) send_tick(1'b1);
    set_config(WAVE_SAW, 32'h8000_0000, PULSE_WIDTH_RESET, PULSE_RECIP_RESET);
    repeat (2) send_tick(1'b1);
    set_config(WAVE_TRIANGLE, 32'hFFFF_FFFF, PULSE_WIDTH_RESET, PULSE_RECIP_RESET);
    repeat (2) send_tick(1'b1);
  endtask

  // pulse width extremes and a reciprocal too large for its width
  task automatic test_pulse_extremes();
    set_config(WAVE_SPARSE, 32'h0345_0000, 16'hFFFF, 32'd65536);
    repeat (2) send_tick(1'b1);
    set_config(WAVE_SPARSE, 32'h0345_0000, 16'h0000, 32'hFFFF_FFFF);
    send_tick(1'b1);
    set_config(WAVE_SPARSE, 32'h0345_0000, 16'h8000, 32'hFFFF_FFFF);
    repeat (2) send_tick(1'b1);
    set_config(WAVE_GATE, 32'h0345_0000, 16'h0000, PULSE_RECIP_RESET);
    send_tick(1'b1);
    set_config(WAVE_SQUARE, 32'h0345_0000, 16'hFFFF, PULSE_RECIP_RESET);
    send_tick(1'b1);
  endtask

  // random settings per phase, random ticks with some zero ticks as noise
  task automatic test_random_settings();
    logic [2:0]  sel;
    logic [31:0] inc;
    logic [15:0] pw;
    logic [31:0] recip;
    logic        t;
    int          sent;
    for (int ph = 0; ph < 13; ph++) begin
      idle_on <= (ph != 6);
      sel = ($urandom_range(15) == 0) ? WAVE_UNUSED : 3'($urandom_range(WAVE_GATE));
      case ($urandom_range(3))
        0: inc = $urandom_range(32'h0100_0000);
        1: inc = $urandom;
        2: inc = 32'h8000_0000 - $urandom_range(255);
        default: inc = $urandom_range(32'h0004_0000);
      endcase
      case ($urandom_range(7))
        0: pw = 16'h0000;
        1: pw = 16'hFFFF;
        default: pw = 16'($urandom);
      endcase
      recip = (pw != 0 && $urandom_range(3) != 0) ? recip_of(pw) : $urandom;
      set_config(sel, inc, pw, recip);
      sent = 0;
      while (sent < 100) begin
        t = ($urandom_range(99) >= 8);
        send_tick(t);
        if (t) sent++;
      end
    end
    idle_on <= 1'b1;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    set_config(WAVE_SINE, $urandom, PULSE_WIDTH_RESET, PULSE_RECIP_RESET);
    stall_go <= ~stall_go;
    repeat (30) send_tick(1'b1);
  endtask

  // sender stops until every sample is back, then resumes mid-waveform
  task automatic test_sender_pause();
    logic [15:0] pw;
    pw = 16'($urandom_range(16'hFFFF, 16'h0100));
    set_config(WAVE_SPARSE, $urandom_range(32'h0200_0000), pw, recip_of(pw));
    repeat (40) send_tick(1'b1);
    wait_drained();
    repeat (40) send_tick(1'b1);
  endtask

  // receiver side: random hold-off, or a long one on request
  always @(posedge clk) begin
    if (stall_go != stall_seen) begin
      stall_seen <= stall_go;
      stall_left <= STALL_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // compare each output transfer with the oldest expected sample
  always @(posedge clk) begin : check_samples
    logic [SAMPLE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample_value %0d", sample_value);
      end else begin
        want = expected_samples.pop_front();
        if (sample_value !== want) begin
          errors++;
          if (errors <= 10)
            $display("sample_value mismatch: expected %0d, got %0d",
                     $signed(want), sample_value);
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // test sequence
  initial begin
    build_sine_rom();
    osc_inc = PHASE_INC_RESET;
    osc_sel = WAVE_SELECT_RESET;
    osc_pw = PULSE_WIDTH_RESET;
    osc_recip = PULSE_RECIP_RESET;
    osc_phase = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_wave_shapes();
    test_phase_wrap();
    test_pulse_extremes();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mwpo_pkg.sv
hw/rtl/mwpo_cfg.sv
hw/rtl/mwpo_ctrl.sv
hw/rtl/mwpo_datapath.sv
hw/rtl/multi_waveform_phase_oscillator.sv
tb/multi_waveform_phase_oscillator_tb.sv
